/* rtl/dds_wavetable_volume_ramp_macros.svh */
// Assertion macros shared by the tone generator RTL.
`ifndef DDS_WAVETABLE_VOLUME_RAMP_MACROS_SVH
`define DDS_WAVETABLE_VOLUME_RAMP_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, off while rst_ni is low.
`define DWVR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Checked on every rising edge of clk_i, reset included.
`define DWVR_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define DWVR_ASSERT(label, prop)
`define DWVR_ASSERT_NR(label, prop)
`endif
`endif

/* rtl/dwvr_pkg.sv */
// Package with widths, defaults, codes and types of the wavetable tone generator.
`default_nettype none

package dwvr_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned TABLE_SIZE_DEF  = 256;
  localparam int unsigned PHASE_SCALE_DEF = 64;
  localparam int unsigned HZ_DIVISOR_DEF  = 61;
  localparam int unsigned VOLUME_MAX_DEF  = 255;

  // Fixed field widths.
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned VOL_W      = 8;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic [FREQ_W-1:0] FREQ_RESET       = 16'd440;
  localparam logic [VOL_W-1:0]  TARGET_VOL_RESET = 8'd127;
  localparam logic              VOLUME_ON_RESET  = 1'b1;

  // The volume moves one step every RAMP_PERIOD ticks.
  localparam int unsigned RAMP_PERIOD = 64;
  localparam int unsigned RAMP_W      = $clog2(RAMP_PERIOD);

  // Latency of the constant divider and of the phase step unit.
  localparam int unsigned CDIV_LAT = 3;
  localparam int unsigned STEP_LAT = 2 * CDIV_LAT + 2;
  localparam int unsigned SETTLE_W = $clog2(STEP_LAT + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQUENCY_HZ  = 2'd0,
    CFG_TARGET_VOLUME = 2'd1,
    CFG_VOLUME_ON     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [VOL_W-1:0] target_volume;
    logic             volume_on;
  } vol_cfg_t;

endpackage

`default_nettype wire

/* rtl/dwvr_stream_if.sv */
// Valid/ready interfaces of the input and result channels.
`default_nettype none

interface dwvr_in_if import dwvr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [IDX_W-1:0]    table_index;
  logic [SAMPLE_W-1:0] table_value;

  modport source (output valid, output kind, output table_index, output table_value,
                  input ready);
  modport sink   (input valid, input kind, input table_index, input table_value,
                  output ready);
endinterface

interface dwvr_out_if import dwvr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty;

  modport source (output valid, output duty, input ready);
  modport sink   (input valid, input duty, output ready);
endinterface

`default_nettype wire

/* rtl/dwvr_cdiv.sv */
// Pipelined divider by a constant: reciprocal multiply and one correction step.
`default_nettype none

module dwvr_cdiv #(
  parameter int unsigned NUM_W   = 16,
  parameter int unsigned DIVISOR = 1,
  localparam int unsigned REM_W  = $clog2(DIVISOR + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  output logic      [NUM_W-1:0] quo_o,
  output logic      [REM_W-1:0] rem_o
);

  localparam int unsigned MUL_W = NUM_W + 1;
  localparam int unsigned PRD_W = 2 * NUM_W + 1;
  localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << NUM_W) / 64'(DIVISOR));
  localparam logic [REM_W-1:0] DIV_C = REM_W'(DIVISOR);
  localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

  logic [PRD_W-1:0]       prod;
  logic [NUM_W+REM_W-1:0] qd;
  logic [NUM_W-1:0]       rem_raw;
  logic [NUM_W-1:0]       qe1_q, num1_q;
  logic [NUM_W-1:0]       qe2_q, num2_q, qd2_q;
  logic [NUM_W-1:0]       quo_d;
  logic [REM_W-1:0]       rem_d;

  // The estimate is the true quotient or one below it.
  assign prod    = PRD_W'(num_i) * PRD_W'(RECIP);
  assign qd      = (NUM_W + REM_W)'(qe1_q) * (NUM_W + REM_W)'(DIV_C);
  assign rem_raw = num2_q - qd2_q;

  always_comb begin
    if (rem_raw >= DIV_N) begin
      quo_d = qe2_q + NUM_W'(1);
      rem_d = REM_W'(rem_raw - DIV_N);
    end else begin
      quo_d = qe2_q;
      rem_d = REM_W'(rem_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe1_q  <= prod[2*NUM_W-1:NUM_W];
      num1_q <= num_i;
      qe2_q  <= qe1_q;
      num2_q <= num1_q;
      qd2_q  <= qd[NUM_W-1:0];
      quo_o  <= quo_d;
      rem_o  <= rem_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/dwvr_step.sv */
// Phase step unit: splits frequency * PHASE_SCALE / HZ_DIVISOR into table and fraction parts.
`default_nettype none

module dwvr_step import dwvr_pkg::*; #(
  parameter int unsigned TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int unsigned PHASE_SCALE = PHASE_SCALE_DEF,
  parameter int unsigned HZ_DIVISOR  = HZ_DIVISOR_DEF,
  localparam int unsigned INT_W  = $clog2(TABLE_SIZE),
  localparam int unsigned FRAC_W = (PHASE_SCALE > 1) ? $clog2(PHASE_SCALE) : 1
) (
  input  wire logic              clk_i,
  input  wire logic [FREQ_W-1:0] freq_i,
  output logic      [INT_W-1:0]  step_int_o,
  output logic      [FRAC_W-1:0] step_frac_o
);

  localparam int unsigned PS_W  = $clog2(PHASE_SCALE + 1);
  localparam int unsigned DIV_W = $clog2(HZ_DIVISOR + 1);
  localparam int unsigned RP_W  = DIV_W + PS_W;

  logic [FREQ_W-1:0] q_int;
  logic [DIV_W-1:0]  r_int;
  logic [RP_W-1:0]   rp_q;
  logic [RP_W-1:0]   q_frac;
  logic [FREQ_W-1:0] sint_pipe_q [CDIV_LAT+1];

  // With f = q*D + r, f*PS/D rounds down to q*PS + (r*PS)/D.
  dwvr_cdiv #(
    .NUM_W  (FREQ_W),
    .DIVISOR(HZ_DIVISOR)
  ) u_div_int (
    .clk_i(clk_i),
    .en_i (1'b1),
    .num_i(freq_i),
    .quo_o(q_int),
    .rem_o(r_int)
  );

  dwvr_cdiv #(
    .NUM_W  (RP_W),
    .DIVISOR(HZ_DIVISOR)
  ) u_div_frac (
    .clk_i(clk_i),
    .en_i (1'b1),
    .num_i(rp_q),
    .quo_o(q_frac),
    .rem_o()
  );

  always_ff @(posedge clk_i) begin
    rp_q           <= RP_W'(r_int) * RP_W'(PHASE_SCALE);
    sint_pipe_q[0] <= q_int;
    for (int i = 1; i <= CDIV_LAT; i++) begin
      sint_pipe_q[i] <= sint_pipe_q[i-1];
    end
    // A step at or past the table span is held one below it.
    if (sint_pipe_q[CDIV_LAT] >= FREQ_W'(TABLE_SIZE)) begin
      step_int_o  <= INT_W'(TABLE_SIZE - 1);
      step_frac_o <= FRAC_W'(PHASE_SCALE - 1);
    end else begin
      step_int_o  <= sint_pipe_q[CDIV_LAT][INT_W-1:0];
      step_frac_o <= q_frac[FRAC_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/dwvr_core.sv */
// Tick pipeline: phase and volume state, wave table, volume scaling and result register.
`default_nettype none
`include "dds_wavetable_volume_ramp_macros.svh"

module dwvr_core import dwvr_pkg::*; #(
  parameter int unsigned TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int unsigned PHASE_SCALE = PHASE_SCALE_DEF,
  parameter int unsigned VOLUME_MAX  = VOLUME_MAX_DEF,
  localparam int unsigned INT_W  = $clog2(TABLE_SIZE),
  localparam int unsigned FRAC_W = (PHASE_SCALE > 1) ? $clog2(PHASE_SCALE) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  dwvr_in_if.sink                in_i,
  dwvr_out_if.source             out_o,
  input  wire logic              hold_i,
  input  wire vol_cfg_t          cfg_i,
  input  wire logic [INT_W-1:0]  step_int_i,
  input  wire logic [FRAC_W-1:0] step_frac_i
);

  localparam int unsigned PROD_W = SAMPLE_W + VOL_W;
  localparam int unsigned WA_W   = ((INT_W > IDX_W) ? INT_W : IDX_W) + 1;
  localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(VOLUME_MAX / 2);
  localparam logic [VOL_W-1:0] VOL_FULL  = VOL_W'(VOLUME_MAX);

  logic                en, accept, tick, wr;
  logic [WA_W-1:0]     wa_x;
  logic [FRAC_W:0]     frac_sum;
  logic                carry;
  logic [INT_W:0]      int_sum;
  logic [INT_W-1:0]    int_n;
  logic [FRAC_W-1:0]   frac_n;

  logic [INT_W-1:0]    int_q, int_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [RAMP_W-1:0]   ramp_q, ramp_d;
  logic [VOL_W-1:0]    vol_q, vol_d;

  logic [SAMPLE_W-1:0] wave_mem [TABLE_SIZE];
  logic [SAMPLE_W-1:0] sample1_q;
  logic [VOL_W-1:0]    factor1_q;
  logic                valid1_q;
  logic [PROD_W-1:0]   prod2_q;
  logic                valid2_q;
  logic [CDIV_LAT-1:0] vpipe_q;
  logic [PROD_W-1:0]   quo;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic                out_valid_q;

  // The whole pipeline moves together; it freezes while a result waits.
  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en && !hold_i;
  assign accept    = in_i.valid && in_i.ready;
  assign tick      = accept && (in_i.kind == KIND_TICK);
  assign wa_x      = WA_W'(in_i.table_index);
  assign wr        = accept && (in_i.kind == KIND_WRITE) && (wa_x < WA_W'(TABLE_SIZE));

  // Phase kept as table index plus fraction below PHASE_SCALE.
  assign frac_sum = (FRAC_W + 1)'(frac_q) + (FRAC_W + 1)'(step_frac_i);
  assign carry    = frac_sum >= (FRAC_W + 1)'(PHASE_SCALE);
  assign int_sum  = (INT_W + 1)'(int_q) + (INT_W + 1)'(step_int_i) + (INT_W + 1)'(carry);

  always_comb begin
    frac_n = carry ? FRAC_W'(frac_sum - (FRAC_W + 1)'(PHASE_SCALE)) : FRAC_W'(frac_sum);
    if (int_sum >= (INT_W + 1)'(TABLE_SIZE)) begin
      int_n = INT_W'(int_sum - (INT_W + 1)'(TABLE_SIZE));
    end else begin
      int_n = INT_W'(int_sum);
    end
  end

  always_comb begin
    int_d  = int_q;
    frac_d = frac_q;
    ramp_d = ramp_q;
    vol_d  = vol_q;
    if (tick) begin
      int_d  = int_n;
      frac_d = frac_n;
      if (cfg_i.volume_on) begin
        ramp_d = ramp_q + RAMP_W'(1);
        if (ramp_d == '0) begin
          if (vol_q > cfg_i.target_volume) begin
            vol_d = vol_q - VOL_W'(1);
          end else if (vol_q < cfg_i.target_volume) begin
            vol_d = vol_q + VOL_W'(1);
          end
        end
      end
    end
  end

  // Table write and registered read at the new phase.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      wave_mem[wa_x[INT_W-1:0]] <= in_i.table_value;
    end
    if (en) begin
      sample1_q <= wave_mem[int_n];
    end
  end

  // With scaling off, multiplying by VOLUME_MAX makes the divide give the sample back.
  always_ff @(posedge clk_i) begin
    if (en) begin
      factor1_q <= cfg_i.volume_on ? vol_d : VOL_FULL;
      prod2_q   <= PROD_W'(sample1_q) * PROD_W'(factor1_q);
      duty_q    <= duty_d;
    end
  end

  dwvr_cdiv #(
    .NUM_W  (PROD_W),
    .DIVISOR(VOLUME_MAX)
  ) u_div_vol (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(prod2_q),
    .quo_o(quo),
    .rem_o()
  );

  assign duty_d = (quo > PROD_W'({DUTY_W{1'b1}})) ? {DUTY_W{1'b1}} : quo[DUTY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q       <= '0;
      frac_q      <= '0;
      ramp_q      <= '0;
      vol_q       <= VOL_RESET;
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      vpipe_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      int_q  <= int_d;
      frac_q <= frac_d;
      ramp_q <= ramp_d;
      vol_q  <= vol_d;
      if (en) begin
        valid1_q    <= tick;
        valid2_q    <= valid1_q;
        vpipe_q     <= {vpipe_q[CDIV_LAT-2:0], valid2_q};
        out_valid_q <= vpipe_q[CDIV_LAT-1];
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.duty  = duty_q;

  `DWVR_ASSERT(a_phase_in_table, (INT_W + 1)'(int_q) < (INT_W + 1)'(TABLE_SIZE))
  `DWVR_ASSERT(a_state_holds_without_tick, !tick |=> ($stable(vol_q) && $stable(ramp_q)))
  `DWVR_ASSERT(a_volume_single_step, tick |=> ((vol_q == $past(vol_q)) || (vol_q == $past(vol_q) + VOL_W'(1)) || (vol_q == $past(vol_q) - VOL_W'(1))))

endmodule

`default_nettype wire

/* rtl/dds_wavetable_volume_ramp.sv */
// Top level of the wavetable tone generator with volume ramp.
//
// Input channel in_i carries beats of two kinds. A table write beat stores
// table_value at table_index and gives no result; an index at or past the
// table size is dropped. A tick beat advances the phase accumulator, runs
// the volume ramp, reads the wave table at the new phase and yields one
// duty beat on out_o. Every table entry must be written before a tick reads it.
// Throughput is one beat per cycle on both channels unless back-pressure on
// out_o, reset or a configuration write stalls intake. A duty beat leaves after
// its tick passes the table read, volume multiply, a three-stage divider by VOLUME_MAX and the result register.
// The configuration port takes frequency_hz, target_volume and volume_on. The user
// must write it only while the block is idle; the block does not enforce this. A
// write, and reset, hold in_i.ready low while the phase step unit (two pipelined
// constant dividers) recomputes the step from the new frequency.
// Reset clears the phase, the ramp counter and all pending results, sets
// the volume to half of VOLUME_MAX and loads the register defaults.
// While a duty beat waits and the receiver holds out_o.ready low, the whole
// tick pipeline freezes and in_i.ready is low in that cycle; nothing is lost
// or repeated. With the result register empty the pipeline keeps moving.
`default_nettype none
`include "dds_wavetable_volume_ramp_macros.svh"

module dds_wavetable_volume_ramp import dwvr_pkg::*; #(
  parameter int unsigned TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int unsigned PHASE_SCALE = PHASE_SCALE_DEF,
  parameter int unsigned HZ_DIVISOR  = HZ_DIVISOR_DEF,
  parameter int unsigned VOLUME_MAX  = VOLUME_MAX_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  dwvr_in_if.sink                    in_i,
  dwvr_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned INT_W  = $clog2(TABLE_SIZE);
  localparam int unsigned FRAC_W = (PHASE_SCALE > 1) ? $clog2(PHASE_SCALE) : 1;

  logic [FREQ_W-1:0]   freq_q, freq_d;
  logic [VOL_W-1:0]    tgt_q, tgt_d;
  logic                von_q, von_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  vol_cfg_t            vol_cfg;
  logic [INT_W-1:0]    step_int;
  logic [FRAC_W-1:0]   step_frac;

  // Register writes. Indexes outside the list are ignored.
  always_comb begin
    freq_d = freq_q;
    tgt_d  = tgt_q;
    von_d  = von_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FREQUENCY_HZ:  freq_d = cfg_wdata_i[FREQ_W-1:0];
        CFG_TARGET_VOLUME: tgt_d  = cfg_wdata_i[VOL_W-1:0];
        CFG_VOLUME_ON:     von_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Intake waits until the step pipeline has flushed the old frequency.
  always_comb begin
    if (cfg_we_i) begin
      settle_d = SETTLE_W'(STEP_LAT);
    end else if (settle_q != '0) begin
      settle_d = settle_q - SETTLE_W'(1);
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q   <= FREQ_RESET;
      tgt_q    <= TARGET_VOL_RESET;
      von_q    <= VOLUME_ON_RESET;
      settle_q <= SETTLE_W'(STEP_LAT);
    end else begin
      freq_q   <= freq_d;
      tgt_q    <= tgt_d;
      von_q    <= von_d;
      settle_q <= settle_d;
    end
  end

  assign vol_cfg.target_volume = tgt_q;
  assign vol_cfg.volume_on     = von_q;

  dwvr_step #(
    .TABLE_SIZE (TABLE_SIZE),
    .PHASE_SCALE(PHASE_SCALE),
    .HZ_DIVISOR (HZ_DIVISOR)
  ) u_step (
    .clk_i      (clk_i),
    .freq_i     (freq_q),
    .step_int_o (step_int),
    .step_frac_o(step_frac)
  );

  dwvr_core #(
    .TABLE_SIZE (TABLE_SIZE),
    .PHASE_SCALE(PHASE_SCALE),
    .VOLUME_MAX (VOLUME_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .hold_i     (settle_q != '0),
    .cfg_i      (vol_cfg),
    .step_int_i (step_int),
    .step_frac_i(step_frac)
  );

  `DWVR_ASSERT(a_cfg_write_blocks_intake, cfg_we_i |=> !in_i.ready)
  `DWVR_ASSERT(a_step_in_span,
    (settle_q == '0) |-> ((INT_W + 1)'(step_int) < (INT_W + 1)'(TABLE_SIZE)))
  `DWVR_ASSERT_NR(a_no_result_in_reset, !rst_ni |-> !out_o.valid)

endmodule

`default_nettype wire
